### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on clk, muted while rst_n is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the same edge
`define ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Implication checked on the following edge
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/cfcm_pkg.sv
// Shared types, constants and tables of the cube face coordinate mapper
package cfcm_pkg;

    localparam int INPUT_BITS_DEF      = 18;
    localparam int COORD_FRAC_BITS_DEF = 15;
    localparam int ATAN_STAGES_DEF     = 16;

    // quotient bits of |n| * 2^30 / d (value up to 2^30)
    localparam int QBITS = 31;
    // CORDIC x/y and angle widths
    localparam int CW    = 34;
    localparam int ZW    = 33;
    localparam int PW    = 64;

    localparam logic [30:0] TAN_K_Q30 = 31'd1269382738;
    localparam logic [30:0] INV_K_Q30 = 31'd1236032962;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // side info that rides along with each word
    typedef struct packed {
        face_t face;
        logic  invalid;
        logic  neg_s;
        logic  neg_t;
    } tag_t;

    // atan(2^-i) in Q30, rounded
    function automatic logic signed [ZW-1:0] stage_angle(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 33'sd843314857;
            1:       r = 33'sd497837829;
            2:       r = 33'sd263043837;
            3:       r = 33'sd133525159;
            4:       r = 33'sd67021687;
            5:       r = 33'sd33543516;
            6:       r = 33'sd16775851;
            7:       r = 33'sd8388437;
            8:       r = 33'sd4194283;
            9:       r = 33'sd2097149;
            10:      r = 33'sd1048576;
            default: r = (i <= 30) ? ZW'(64'd1 << (30 - i)) : ZW'(1);
        endcase
        return r;
    endfunction

endpackage

### rtl/core/cfcm_dir_if.sv
// Direction word channel
interface cfcm_dir_if #(
    parameter int INPUT_BITS = cfcm_pkg::INPUT_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [INPUT_BITS-1:0] direction_x;
    logic signed [INPUT_BITS-1:0] direction_y;
    logic signed [INPUT_BITS-1:0] direction_z;

    modport source (output valid, direction_x, direction_y, direction_z, input ready);
    modport sink   (input valid, direction_x, direction_y, direction_z, output ready);
endinterface

### rtl/core/cfcm_res_if.sv
// Result word channel
interface cfcm_res_if #(
    parameter int COORD_FRAC_BITS = cfcm_pkg::COORD_FRAC_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [2:0]                      face_index;
    logic signed [COORD_FRAC_BITS:0] coord_s;
    logic signed [COORD_FRAC_BITS:0] coord_t;
    logic                            invalid_direction;

    modport source (output valid, face_index, coord_s, coord_t, invalid_direction,
                    input ready);
    modport sink   (input valid, face_index, coord_s, coord_t, invalid_direction,
                    output ready);
endinterface

### rtl/core/cube_face_coordinate_mapper_core.sv
// Cube face selector with inverse warp: top level pipeline
//
// Channel     Modport  Word
// direction   sink     direction_x, direction_y, direction_z
// result      source   face_index, coord_s, coord_t, invalid_direction
//
// One word per cycle in and out while the result is taken; the stages are
// front end, 31 division cells, tan multiply, ATAN_STAGES CORDIC cells,
// 1/K multiply and output register. Every stage moves together: a stalled
// result holds the whole chain, and ready is low only while it waits.
// Reset clears the valid bits only.
module cube_face_coordinate_mapper_core #(
    parameter int INPUT_BITS      = cfcm_pkg::INPUT_BITS_DEF,
    parameter int COORD_FRAC_BITS = cfcm_pkg::COORD_FRAC_BITS_DEF,
    parameter int ATAN_STAGES     = cfcm_pkg::ATAN_STAGES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cfcm_dir_if.sink   direction,
    cfcm_res_if.source result
);
    import cfcm_pkg::*;
    `include "assert_macros.svh"

    localparam int SH = 60 - COORD_FRAC_BITS;
    localparam logic [PW-1:0] LIM   = (PW'(1) << COORD_FRAC_BITS) - PW'(1);
    localparam logic [PW-1:0] RHALF = PW'(1) << (SH - 1);
    localparam int IW = INPUT_BITS + 1;

    logic en;

    // ---------------- front end: face pick and tangent select
    logic signed [IW-1:0] xe, ye, ze, ax, ay, az, ns, nt, dd, as_n, at_n;
    face_t                face_sel;
    tag_t                 fe_tag_next;

    always_comb
    begin
        xe = IW'(direction.direction_x);
        ye = IW'(direction.direction_y);
        ze = IW'(direction.direction_z);
        ax = xe[IW-1] ? -xe : xe;
        ay = ye[IW-1] ? -ye : ye;
        az = ze[IW-1] ? -ze : ze;
        if (ax >= ay && ax >= az)
            face_sel = (xe > 0) ? FACE_POS_X : FACE_NEG_X;
        else if (ay >= az)
            face_sel = (ye > 0) ? FACE_POS_Y : FACE_NEG_Y;
        else
            face_sel = (ze > 0) ? FACE_POS_Z : FACE_NEG_Z;
        case (face_sel)
            FACE_POS_X: begin ns = -ze; nt = ye;  dd = xe;  end
            FACE_NEG_X: begin ns = ze;  nt = ye;  dd = -xe; end
            FACE_POS_Y: begin ns = xe;  nt = -ze; dd = ye;  end
            FACE_NEG_Y: begin ns = xe;  nt = ze;  dd = -ye; end
            FACE_POS_Z: begin ns = xe;  nt = ye;  dd = ze;  end
            default:    begin ns = -xe; nt = ye;  dd = -ze; end
        endcase
        as_n = ns[IW-1] ? -ns : ns;
        at_n = nt[IW-1] ? -nt : nt;
        fe_tag_next.invalid = (ax == 0) && (ay == 0) && (az == 0);
        fe_tag_next.face    = fe_tag_next.invalid ? FACE_POS_X : face_sel;
        fe_tag_next.neg_s   = ns[IW-1];
        fe_tag_next.neg_t   = nt[IW-1];
    end

    logic                        fe_valid_reg;
    tag_t                        fe_tag_reg;
    logic [INPUT_BITS-1:0]       fe_den_reg;
    logic [1:0][INPUT_BITS-1:0]  fe_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fe_valid_reg <= 1'b0;
        else if (en)
            fe_valid_reg <= direction.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fe_tag_reg    <= fe_tag_next;
            fe_den_reg    <= dd[INPUT_BITS-1:0];
            fe_mag_reg[0] <= as_n[INPUT_BITS-1:0];
            fe_mag_reg[1] <= at_n[INPUT_BITS-1:0];
        end
    end

    // ---------------- division chain
    logic                       dv_valid [0:QBITS];
    tag_t                       dv_tag   [0:QBITS];
    logic [INPUT_BITS-1:0]      dv_den   [0:QBITS];
    logic [1:0][INPUT_BITS-1:0] dv_rem   [0:QBITS];
    logic [1:0][QBITS-1:0]      dv_q     [0:QBITS];

    assign dv_valid[0] = fe_valid_reg;
    assign dv_tag[0]   = fe_tag_reg;
    assign dv_den[0]   = fe_den_reg;
    assign dv_rem[0]   = fe_mag_reg;
    assign dv_q[0]     = '0;

    for (genvar k = 0; k < QBITS; k++)
    begin : g_div
        cfcm_div_cell #(.INPUT_BITS(INPUT_BITS)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_valid[k]),
            .tag_in    (dv_tag[k]),
            .den_in    (dv_den[k]),
            .rem_in    (dv_rem[k]),
            .q_in      (dv_q[k]),
            .valid_out (dv_valid[k+1]),
            .tag_out   (dv_tag[k+1]),
            .den_out   (dv_den[k+1]),
            .rem_out   (dv_rem[k+1]),
            .q_out     (dv_q[k+1])
        );
    end

    // ---------------- scale by tan K
    logic              ml_valid_reg;
    tag_t              ml_tag_reg;
    logic [1:0][31:0]  ml_w_reg, ml_w_next;

    always_comb
    begin
        logic [61:0] prod;
        for (int l = 0; l < 2; l++)
        begin
            prod         = 62'(dv_q[QBITS][l]) * 62'(TAN_K_Q30);
            ml_w_next[l] = prod[61:30];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ml_valid_reg <= 1'b0;
        else if (en)
            ml_valid_reg <= dv_valid[QBITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ml_tag_reg <= dv_tag[QBITS];
            ml_w_reg   <= ml_w_next;
        end
    end

    // ---------------- CORDIC chain
    logic               cr_valid [0:ATAN_STAGES];
    tag_t               cr_tag   [0:ATAN_STAGES];
    logic [1:0][CW-1:0] cr_x     [0:ATAN_STAGES];
    logic [1:0][CW-1:0] cr_y     [0:ATAN_STAGES];
    logic [1:0][ZW-1:0] cr_z     [0:ATAN_STAGES];

    assign cr_valid[0] = ml_valid_reg;
    assign cr_tag[0]   = ml_tag_reg;
    assign cr_x[0][0]  = CW'(64'd1 << 30);
    assign cr_x[0][1]  = CW'(64'd1 << 30);
    assign cr_y[0][0]  = CW'(ml_w_reg[0]);
    assign cr_y[0][1]  = CW'(ml_w_reg[1]);
    assign cr_z[0]     = '0;

    for (genvar i = 0; i < ATAN_STAGES; i++)
    begin : g_cordic
        cfcm_cordic_cell #(.STAGE(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cr_valid[i]),
            .tag_in    (cr_tag[i]),
            .x_in      (cr_x[i]),
            .y_in      (cr_y[i]),
            .z_in      (cr_z[i]),
            .valid_out (cr_valid[i+1]),
            .tag_out   (cr_tag[i+1]),
            .x_out     (cr_x[i+1]),
            .y_out     (cr_y[i+1]),
            .z_out     (cr_z[i+1])
        );
    end

    // ---------------- scale angle by 1/K
    logic              sc_valid_reg;
    tag_t              sc_tag_reg;
    logic [1:0][PW-1:0] sc_p_reg, sc_p_next;

    always_comb
    begin
        logic [31:0] zc;
        for (int l = 0; l < 2; l++)
        begin
            zc           = cr_z[ATAN_STAGES][l][ZW-1] ? 32'd0 : cr_z[ATAN_STAGES][l][31:0];
            sc_p_next[l] = PW'(zc) * PW'(INV_K_Q30);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else if (en)
            sc_valid_reg <= cr_valid[ATAN_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_tag_reg <= cr_tag[ATAN_STAGES];
            sc_p_reg   <= sc_p_next;
        end
    end

    // ---------------- round, saturate, sign
    logic [1:0][COORD_FRAC_BITS:0] crd_next;

    always_comb
    begin
        logic [PW-1:0]            r;
        logic [COORD_FRAC_BITS:0] mag;
        logic                     neg;
        for (int l = 0; l < 2; l++)
        begin
            r   = (sc_p_reg[l] + RHALF) >> SH;
            mag = (r > LIM) ? LIM[COORD_FRAC_BITS:0] : r[COORD_FRAC_BITS:0];
            neg = (l == 0) ? sc_tag_reg.neg_s : sc_tag_reg.neg_t;
            if (sc_tag_reg.invalid)
                crd_next[l] = '0;
            else
                crd_next[l] = neg ? -mag : mag;
        end
    end

    // ---------------- output register
    logic                            res_valid_reg;
    face_t                           res_face_reg;
    logic [1:0][COORD_FRAC_BITS:0]   res_crd_reg;
    logic                            res_inv_reg;

    assign en = !res_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= sc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_face_reg <= sc_tag_reg.face;
            res_crd_reg  <= crd_next;
            res_inv_reg  <= sc_tag_reg.invalid;
        end
    end

    assign direction.ready          = en;
    assign result.valid             = res_valid_reg;
    assign result.face_index        = res_face_reg;
    assign result.coord_s           = $signed(res_crd_reg[0]);
    assign result.coord_t           = $signed(res_crd_reg[1]);
    assign result.invalid_direction = res_inv_reg;

    // ---------------- checks
    `ASSERT_IMPL(a_invalid_zero, res_valid_reg && res_inv_reg,
        res_face_reg == FACE_POS_X && res_crd_reg[0] == 0 && res_crd_reg[1] == 0,
        "zero direction word not cleared")
    `ASSERT_IMPL(a_no_min_code, res_valid_reg,
        res_crd_reg[0] != {1'b1, {COORD_FRAC_BITS{1'b0}}} &&
        res_crd_reg[1] != {1'b1, {COORD_FRAC_BITS{1'b0}}},
        "coordinate hit the most negative code")
    `ASSERT_NEXT(a_stall_holds, !en, $stable(fe_valid_reg) && $stable(sc_valid_reg),
        "pipeline moved during a stall")
    `ASSERT_CLK(a_ready_rule, direction.ready == (!res_valid_reg || result.ready),
        "ready does not follow the output stage")
endmodule

### rtl/core/cfcm_div_cell.sv
// One restoring-division cell: one quotient bit for both tangent lanes
module cfcm_div_cell #(
    parameter int INPUT_BITS = cfcm_pkg::INPUT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  valid_in,
    input  cfcm_pkg::tag_t                        tag_in,
    input  logic [INPUT_BITS-1:0]                 den_in,
    input  logic [1:0][INPUT_BITS-1:0]            rem_in,
    input  logic [1:0][cfcm_pkg::QBITS-1:0]       q_in,
    output logic                                  valid_out,
    output cfcm_pkg::tag_t                        tag_out,
    output logic [INPUT_BITS-1:0]                 den_out,
    output logic [1:0][INPUT_BITS-1:0]            rem_out,
    output logic [1:0][cfcm_pkg::QBITS-1:0]       q_out
);
    import cfcm_pkg::*;

    logic                           valid_reg;
    tag_t                           tag_reg;
    logic [INPUT_BITS-1:0]          den_reg;
    logic [1:0][INPUT_BITS-1:0]     rem_reg, rem_next;
    logic [1:0][QBITS-1:0]          q_reg, q_next;

    // compare, subtract, shift
    always_comb
    begin
        logic                  ge;
        logic [INPUT_BITS-1:0] r1;
        for (int l = 0; l < 2; l++)
        begin
            ge          = (rem_in[l] >= den_in);
            r1          = ge ? (rem_in[l] - den_in) : rem_in[l];
            rem_next[l] = {r1[INPUT_BITS-2:0], 1'b0};
            q_next[l]   = {q_in[l][QBITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg <= tag_in;
            den_reg <= den_in;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign valid_out = valid_reg;
    assign tag_out   = tag_reg;
    assign den_out   = den_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
endmodule

### rtl/core/cfcm_cordic_cell.sv
// One vectoring CORDIC micro-rotation for both tangent lanes
module cfcm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               valid_in,
    input  cfcm_pkg::tag_t                     tag_in,
    input  logic [1:0][cfcm_pkg::CW-1:0]       x_in,
    input  logic [1:0][cfcm_pkg::CW-1:0]       y_in,
    input  logic [1:0][cfcm_pkg::ZW-1:0]       z_in,
    output logic                               valid_out,
    output cfcm_pkg::tag_t                     tag_out,
    output logic [1:0][cfcm_pkg::CW-1:0]       x_out,
    output logic [1:0][cfcm_pkg::CW-1:0]       y_out,
    output logic [1:0][cfcm_pkg::ZW-1:0]       z_out
);
    import cfcm_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = stage_angle(STAGE);

    logic                valid_reg;
    tag_t                tag_reg;
    logic [1:0][CW-1:0]  x_reg, x_next;
    logic [1:0][CW-1:0]  y_reg, y_next;
    logic [1:0][ZW-1:0]  z_reg, z_next;

    // rotate toward y = 0 using old x and y
    always_comb
    begin
        logic signed [CW-1:0] xs, ys, dx, dy;
        logic signed [ZW-1:0] zs;
        for (int l = 0; l < 2; l++)
        begin
            xs = $signed(x_in[l]);
            ys = $signed(y_in[l]);
            zs = $signed(z_in[l]);
            dx = ys >>> STAGE;
            dy = xs >>> STAGE;
            if (!ys[CW-1])
            begin
                x_next[l] = xs + dx;
                y_next[l] = ys - dy;
                z_next[l] = zs + ANGLE;
            end
            else
            begin
                x_next[l] = xs - dx;
                y_next[l] = ys + dy;
                z_next[l] = zs - ANGLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg <= tag_in;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    assign valid_out = valid_reg;
    assign tag_out   = tag_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
endmodule
